// File: hw/rtl/kalman_angle_bias_filter_unit_macros.svh
`ifndef KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define KAB_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// implication checked in the following cycle
`define KAB_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/kab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kab_pkg;
  localparam int FRAC = 24;

  // datapath operations issued by the controller
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_ANG    = 5'd1;
  localparam logic [4:0] OP_P00    = 5'd2;
  localparam logic [4:0] OP_DP11   = 5'd3;
  localparam logic [4:0] OP_P11    = 5'd4;
  localparam logic [4:0] OP_S      = 5'd5;
  localparam logic [4:0] OP_K0DIV  = 5'd6;
  localparam logic [4:0] OP_K1DIV  = 5'd7;
  localparam logic [4:0] OP_ANGC   = 5'd8;
  localparam logic [4:0] OP_BIASC  = 5'd9;
  localparam logic [4:0] OP_C00    = 5'd10;
  localparam logic [4:0] OP_C01    = 5'd11;
  localparam logic [4:0] OP_C10    = 5'd12;
  localparam logic [4:0] OP_C11    = 5'd13;
  localparam logic [4:0] OP_COMMIT = 5'd14;
  localparam logic [4:0] OP_LOAD   = 5'd15;
  localparam logic [4:0] OP_QDT    = 5'd16;

  localparam logic [1:0] REG_DT = 2'd0;
  localparam logic [1:0] REG_QA = 2'd1;
  localparam logic [1:0] REG_QB = 2'd2;
  localparam logic [1:0] REG_RM = 2'd3;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round half up, shift by FRAC
  function automatic logic signed [71:0] rnd(input logic signed [71:0] x);
    logic signed [71:0] t;
    t = x + (72'sd1 <<< (FRAC - 1));
    return t >>> FRAC;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/kalman_angle_bias_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Each input runs through the controller states, including two 56-step gain divides, before its result is valid.
// A new input is not taken until the previous one is committed; one serial divider is shared by both gains.
// A new input is taken while the previous result waits if out_ready is high.
// Reset (synchronous, rst high) zeroes state and restores register defaults.
module kalman_angle_bias_filter_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [24:0] accel_angle,
  input  wire logic signed [31:0] gyro_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      filtered_angle,
  output logic signed [31:0]      gyro_bias,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  kab_pkg::cmd_t    cmd;
  kab_pkg::status_t status;

  assign cfg_ready = 1'b1;

  kab_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready), .in_rdy(in_ready),
    .out_vld(out_valid), .out_rdy(out_ready), .status(status), .cmd(cmd)
  );

  kab_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_valid), .cfg_sel(cfg_index), .cfg_val(cfg_data),
    .in_acc(accel_angle), .in_rate(gyro_rate),
    .angle_out(filtered_angle), .bias_out(gyro_bias)
  );
endmodule
`default_nettype wire

// File: hw/rtl/kab_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// signed restoring divider, one quotient bit per cycle, truncates toward zero
module kab_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic        [32:0] den,
  output logic                    busy,
  output logic signed [31:0]      quot
);
  logic [55:0] q;
  logic [56:0] rem;
  logic [32:0] d;
  logic        neg;
  logic [5:0]  cnt;
  logic [56:0] trial;
  logic [56:0] shifted;

  assign shifted = {rem[55:0], q[55]};
  assign trial = shifted - {24'd0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd56;
      neg  <= num[31];
      q    <= {(num[31] ? 32'(-num) : 32'(num)), 24'd0};
      rem  <= '0;
      d    <= den;
    end else if (busy) begin
      if (!trial[56]) begin
        rem <= trial;
        q   <= {q[54:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[54:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  logic signed [71:0] sq;
  always_comb begin
    sq = neg ? -$signed({16'd0, q}) : $signed({16'd0, q});
    quot = kab_pkg::sat32(sq);
  end
endmodule
`default_nettype wire

// File: hw/rtl/kab_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module kab_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kab_pkg::cmd_t       cmd,
  output kab_pkg::status_t         status,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_sel,
  input  wire logic [23:0]         cfg_val,
  input  wire logic signed [24:0]  in_acc,
  input  wire logic signed [31:0]  in_rate,
  output logic signed [31:0]       angle_out,
  output logic signed [31:0]       bias_out
);
  logic [23:0] dt, qa, qb, rm;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [31:0] w_ang, w_bias, w00, w01, w10, w11, k0, k1, innov;
  logic signed [31:0] acc, rate;
  logic signed [48:0] qdt;
  logic signed [32:0] s;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  logic signed [71:0] prod, r;
  logic               div_start;
  logic signed [31:0] div_num;
  logic signed [31:0] quot;
  logic               div_busy;

  kab_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(s[32:0]), .busy(div_busy), .quot(quot)
  );
  assign status.div_busy = div_busy;

  // one shared multiplier, operand selection by op
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      kab_pkg::OP_ANG:   begin ma = {9'd0, dt}; mb = 33'(rate) - 33'(w_bias); end
      kab_pkg::OP_QDT:   begin ma = {9'd0, qa}; mb = {9'd0, dt}; end
      kab_pkg::OP_P00:   begin ma = {9'd0, dt}; mb = 33'(w10) + 33'(w01); end
      kab_pkg::OP_DP11:  begin ma = {9'd0, dt}; mb = 33'(w11); end
      kab_pkg::OP_P11:   begin ma = {9'd0, qb}; mb = {9'd0, dt}; end
      kab_pkg::OP_ANGC:  begin ma = 33'(k0); mb = 33'(innov); end
      kab_pkg::OP_BIASC: begin ma = 33'(k1); mb = 33'(innov); end
      kab_pkg::OP_C00:   begin ma = 33'(k0); mb = 33'(w00); end
      kab_pkg::OP_C01:   begin ma = 33'(k0); mb = 33'(w01); end
      kab_pkg::OP_C10:   begin ma = 33'(k1); mb = 33'(w00); end
      kab_pkg::OP_C11:   begin ma = 33'(k1); mb = 33'(w01); end
      default:           begin ma = '0; mb = '0; end
    endcase
    mprod = 66'(ma) * 66'(mb);
    prod = 72'(mprod);
    r = kab_pkg::rnd(prod);
  end

  assign div_start = (cmd.op == kab_pkg::OP_K0DIV) || (cmd.op == kab_pkg::OP_K1DIV);
  assign div_num = (cmd.op == kab_pkg::OP_K1DIV) ? w10 : w00;

  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= 24'd167772; qa <= 24'd167772; qb <= 24'd5033; rm <= 24'd167772;
      ang <= '0; bias <= '0; p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_sel)
          kab_pkg::REG_DT: dt <= cfg_val;
          kab_pkg::REG_QA: qa <= cfg_val;
          kab_pkg::REG_QB: qb <= cfg_val;
          kab_pkg::REG_RM: rm <= cfg_val;
          default: ;
        endcase
      end
      if (cmd.op == kab_pkg::OP_COMMIT) begin
        ang <= w_ang; bias <= w_bias; p00 <= w00; p01 <= w01; p10 <= w10; p11 <= w11;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      kab_pkg::OP_LOAD: begin
        acc <= 32'(in_acc); rate <= in_rate;
        w_ang <= ang; w_bias <= bias; w00 <= p00; w01 <= p01; w10 <= p10; w11 <= p11;
        k0 <= '0; k1 <= '0;
      end
      kab_pkg::OP_ANG: begin
        w_ang <= kab_pkg::sat32(72'(w_ang) + r);
        innov <= kab_pkg::sat32(72'(acc) - 72'(kab_pkg::sat32(72'(w_ang) + r)));
      end
      kab_pkg::OP_QDT: qdt <= 49'(prod);
      kab_pkg::OP_P00: w00 <= kab_pkg::sat32(72'(w00) + kab_pkg::rnd(72'(qdt) - prod));
      kab_pkg::OP_DP11: begin
        w01 <= kab_pkg::sat32(72'(w01) - r);
        w10 <= kab_pkg::sat32(72'(w10) - r);
      end
      kab_pkg::OP_P11: w11 <= kab_pkg::sat32(72'(w11) + r);
      kab_pkg::OP_S:   s <= 33'(w00) + 33'(rm);
      kab_pkg::OP_K0DIV: ;
      kab_pkg::OP_K1DIV: if (s > 0) k0 <= quot;
      kab_pkg::OP_ANGC: begin
        if (s > 0) k1 <= quot;
        w_ang <= kab_pkg::sat32(72'(w_ang) + r);
      end
      kab_pkg::OP_BIASC: w_bias <= kab_pkg::sat32(72'(w_bias) + r);
      kab_pkg::OP_C00: w00 <= kab_pkg::sat32(72'(w00) - r);
      kab_pkg::OP_C01: w01 <= kab_pkg::sat32(72'(w01) - r);
      kab_pkg::OP_C10: w10 <= kab_pkg::sat32(72'(w10) - r);
      kab_pkg::OP_C11: w11 <= kab_pkg::sat32(72'(w11) - r);
      default: ;
    endcase
  end

  assign angle_out = ang;
  assign bias_out = bias;
endmodule
`default_nettype wire

// File: hw/rtl/kab_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module kab_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_fire,
  output logic                  in_rdy,
  output logic                  out_vld,
  input  wire logic             out_rdy,
  input  wire kab_pkg::status_t status,
  output kab_pkg::cmd_t         cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_ANG = 4'd1, S_QDT = 4'd2, S_P00 = 4'd3,
    S_DP11 = 4'd4, S_P11 = 4'd5, S_S = 4'd6, S_D0 = 4'd7, S_W0 = 4'd8, S_D1 = 4'd9,
    S_W1 = 4'd10, S_ANGC = 4'd11, S_REST = 4'd12, S_COMMIT = 4'd13;
  logic [3:0] state, state_next;
  logic [2:0] step, step_next;
  logic       pend, pend_next;

  assign in_rdy = (state == S_IDLE) && (!out_vld || out_rdy);
  assign out_vld = pend;

  always_comb begin
    state_next = state;
    step_next = step;
    pend_next = pend && !out_rdy;
    cmd.op = kab_pkg::OP_NONE;
    case (state)
      S_IDLE: if (in_fire) begin cmd.op = kab_pkg::OP_LOAD; state_next = S_ANG; end
      S_ANG:  begin cmd.op = kab_pkg::OP_ANG; state_next = S_QDT; end
      S_QDT:  begin cmd.op = kab_pkg::OP_QDT; state_next = S_P00; end
      S_P00:  begin cmd.op = kab_pkg::OP_P00; state_next = S_DP11; end
      S_DP11: begin cmd.op = kab_pkg::OP_DP11; state_next = S_P11; end
      S_P11:  begin cmd.op = kab_pkg::OP_P11; state_next = S_S; end
      S_S:    begin cmd.op = kab_pkg::OP_S; state_next = S_D0; end
      S_D0:   begin cmd.op = kab_pkg::OP_K0DIV; state_next = S_W0; end
      S_W0:   if (!status.div_busy) state_next = S_D1;
      // K1 divide starts while K0 is captured
      S_D1:   begin cmd.op = kab_pkg::OP_K1DIV; state_next = S_W1; end
      S_W1:   if (!status.div_busy) state_next = S_ANGC;
      S_ANGC: begin cmd.op = kab_pkg::OP_ANGC; state_next = S_REST; step_next = '0; end
      S_REST: begin
        case (step)
          3'd0: cmd.op = kab_pkg::OP_BIASC;
          3'd1: cmd.op = kab_pkg::OP_C00;
          3'd2: cmd.op = kab_pkg::OP_C01;
          3'd3: cmd.op = kab_pkg::OP_C10;
          default: cmd.op = kab_pkg::OP_C11;
        endcase
        step_next = step + 3'd1;
        if (step == 3'd4) state_next = S_COMMIT;
      end
      S_COMMIT: begin cmd.op = kab_pkg::OP_COMMIT; pend_next = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      pend <= pend_next;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/kab_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "kalman_angle_bias_filter_unit_macros.svh"
module kab_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] filtered_angle
);
  // no new transfer right after one while work runs
  `KAB_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready)
  // result appears only after long compute, never the cycle after a transfer
  `KAB_ASSERT_NEXT(a_noimm, clk, rst, in_valid && in_ready && !out_valid, !out_valid)
  `KAB_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(filtered_angle))
endmodule
bind kalman_angle_bias_filter_unit kab_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .filtered_angle(filtered_angle)
);
`default_nettype wire
